// ===== hw/rtl/tcra_pkg.sv =====
// Shared types and constants for the three-class runway arbiter.
// No dependencies; every other file of the block refers to this package by scoped names.
package tcra_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STAMP_W     = 32;
	localparam int LIMIT_W     = 5;
	localparam int SHARE_W     = 4;
	localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int PID_W       = 16;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 88;

	typedef enum logic [1:0] {
		OP_ARR   = 2'd0,
		OP_EMG   = 2'd1,
		OP_DEP   = 2'd2,
		OP_GRANT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_ARR = 2'd0,
		CLS_EMG = 2'd1,
		CLS_DEP = 2'd2
	} cls_t;

	localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARE_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPART_SHARE  = 2'd2;

	// A classified word handed from the front end to the back end.
	typedef struct packed {
		logic               is_grant;
		cls_t               cls;
		logic [STAMP_W-1:0] stamp;
	} cmd_t;

	// One queue entry: plane ID and request time.
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic               accepted;
		logic [PID_W-1:0]   flight_id;
		cls_t               served_class;
		logic [STAMP_W-1:0] request_stamp;
		logic [STAMP_W-1:0] wait_time;
	} result_t;

endpackage

// ===== hw/rtl/three_class_runway_arbiter.sv =====
// Top level of the three-class runway arbiter: front end, back end and port packing.
// Depends on tcra_pkg, tcra_front and tcra_back.
//
// The arbiter keeps three request queues of 16 entries each (emergency, arrival,
// departure). A request word enqueues a plane into the class its op names, with ID
// 2n for arrivals or 2n+1 for departures from a running counter; a full queue
// rejects the request with accepted low. A grant word serves emergency first, then
// a departure when the share counter is below depart_share and the departure
// backlog exceeds depart_backlog_limit (both rules waived when no arrival waits),
// else an arrival, and reports the ID, class, request time and wait time. Exactly
// one result word comes out for every input word, in order. The front end buffers
// up to two input words while the back end works. In the back end a grant word that
// finds a plane goes from the idle state to a read state, because the queue memories
// have a registered read port, and no new word is taken until the read is done; the
// request rate is one word per cycle unless a result stalls. A result waiting on
// m_tready holds the back end but not the front end. Configuration registers may
// be written only while no word is in flight; there is no clearing pass after reset.
module three_class_runway_arbiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcra_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: op [1:0], time_now [33:2], zero fill [39:34].
	input  logic [tcra_pkg::IN_W-1:0]        s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0 up: accepted [0], flight_id [16:1], served_class [18:17],
	// request_stamp [50:19], wait_time [82:51], zero fill [87:83].
	output logic [tcra_pkg::OUT_W-1:0]       m_tdata
);

	logic              cmd_valid;
	logic              cmd_pop;
	tcra_pkg::cmd_t    cmd;
	tcra_pkg::result_t result;

	tcra_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tcra_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	// First field in the lowest bits.
	assign m_tdata = {5'b0, result.wait_time, result.request_stamp,
		result.served_class, result.flight_id, result.accepted};

endmodule

// ===== hw/rtl/tcra_fifo.sv =====
// One request queue of the runway arbiter: a circular buffer with head and count.
// Depends on tcra_pkg for depth and entry layout. The head read is registered.
module tcra_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcra_pkg::entry_t      push_entry,
	input  logic                  pop,
	output tcra_pkg::entry_t      rd_data_q,
	output logic [tcra_pkg::CNT_W-1:0] count
);

	tcra_pkg::entry_t mem [tcra_pkg::QUEUE_DEPTH];

	logic [tcra_pkg::PTR_W-1:0] head_q;
	logic [tcra_pkg::CNT_W-1:0] cnt_q;
	logic [tcra_pkg::PTR_W:0]   tail_sum;
	logic [tcra_pkg::PTR_W-1:0] tail;
	logic [tcra_pkg::PTR_W-1:0] head_next;

	assign count = cnt_q;

	always_comb begin
		tail_sum = {1'b0, head_q} + (tcra_pkg::PTR_W + 1)'(cnt_q);
		if (tail_sum >= (tcra_pkg::PTR_W + 1)'(tcra_pkg::QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (tcra_pkg::PTR_W + 1)'(tcra_pkg::QUEUE_DEPTH);
		end
		tail = tail_sum[tcra_pkg::PTR_W-1:0];
		if (head_q == tcra_pkg::PTR_W'(tcra_pkg::QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail] <= push_entry;
		end
		if (pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_next;
				cnt_q  <= cnt_q - 1'b1;
			end else if (push) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tcra_front.sv =====
// Front end of the runway arbiter: accepts input words, classifies them and
// holds them in a two-entry command queue. Depends on tcra_pkg.
module tcra_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [tcra_pkg::IN_W-1:0] s_tdata,
	output logic                      cmd_valid,
	output tcra_pkg::cmd_t            cmd,
	input  logic                      cmd_pop
);

	tcra_pkg::cmd_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	tcra_pkg::op_t  op;
	tcra_pkg::cmd_t cmd_in;
	logic           take;

	assign s_tready  = (cnt_q != 2'd2);
	assign take      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];

	always_comb begin
		op              = tcra_pkg::op_t'(s_tdata[1:0]);
		cmd_in.stamp    = s_tdata[tcra_pkg::STAMP_W+1:2];
		cmd_in.is_grant = 1'b0;
		case (op)
			tcra_pkg::OP_ARR: cmd_in.cls = tcra_pkg::CLS_ARR;
			tcra_pkg::OP_EMG: cmd_in.cls = tcra_pkg::CLS_EMG;
			tcra_pkg::OP_DEP: cmd_in.cls = tcra_pkg::CLS_DEP;
			default: begin
				cmd_in.cls      = tcra_pkg::CLS_ARR;
				cmd_in.is_grant = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({take, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tcra_back.sv =====
// Back end of the runway arbiter: configuration registers, the three class queues,
// the grant decision, ID and share counters, and the result register.
// Depends on tcra_pkg and tcra_fifo.
module tcra_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcra_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            cmd_valid,
	input  tcra_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tcra_pkg::result_t               out_result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                              state_q;
	logic                                out_valid_q;
	tcra_pkg::result_t                   result_q;
	logic [tcra_pkg::ID_BITS-2:0]        id_ctr_q;
	logic [tcra_pkg::SHARE_W-1:0]        share_q;
	logic [tcra_pkg::LIMIT_W-1:0]        limit_q;
	logic [tcra_pkg::SHARE_W-1:0]        window_q;
	logic [tcra_pkg::SHARE_W-1:0]        dshare_q;
	tcra_pkg::cls_t                      sel_cls_q;
	logic [tcra_pkg::STAMP_W-1:0]        now_q;

	logic [tcra_pkg::CNT_W-1:0] emg_cnt, arr_cnt, dep_cnt, tgt_cnt;
	tcra_pkg::entry_t           emg_rd, arr_rd, dep_rd, sel_rd;
	tcra_pkg::entry_t           new_entry;
	logic [tcra_pkg::ID_BITS-1:0] new_id;
	logic [31:0]                id_ext;
	logic                       slot_free, do_cmd, full, req_ok;
	logic                       emg_ne, arr_e, dep_ne, any_ne, dep_pick, do_grant;
	tcra_pkg::cls_t             gcls;
	logic                       out_load;
	tcra_pkg::result_t          res_d;
	logic [tcra_pkg::SHARE_W:0] share_inc;

	assign out_valid  = out_valid_q;
	assign out_result = result_q;
	assign slot_free  = !out_valid_q || out_ready;
	assign do_cmd     = (state_q == ST_IDLE) && cmd_valid && slot_free;
	assign cmd_pop    = do_cmd;

	always_comb begin
		case (cmd.cls)
			tcra_pkg::CLS_EMG: tgt_cnt = emg_cnt;
			tcra_pkg::CLS_DEP: tgt_cnt = dep_cnt;
			default:           tgt_cnt = arr_cnt;
		endcase
		full      = (tgt_cnt == tcra_pkg::CNT_W'(tcra_pkg::QUEUE_DEPTH));
		new_id    = {id_ctr_q, cmd.cls == tcra_pkg::CLS_DEP};
		new_entry = '{id: new_id, stamp: cmd.stamp};
		req_ok    = do_cmd && !cmd.is_grant && !full;

		// Emergency first, then a departure when both the share and backlog rules
		// allow it (either rule is waived when no arrival waits), else an arrival.
		emg_ne   = (emg_cnt != '0);
		arr_e    = (arr_cnt == '0);
		dep_ne   = (dep_cnt != '0);
		any_ne   = emg_ne || !arr_e || dep_ne;
		dep_pick = dep_ne && ((share_q < dshare_q) || arr_e)
			&& ((tcra_pkg::CMP_W'(dep_cnt) > tcra_pkg::CMP_W'(limit_q)) || arr_e);
		if (emg_ne) begin
			gcls = tcra_pkg::CLS_EMG;
		end else if (dep_pick) begin
			gcls = tcra_pkg::CLS_DEP;
		end else begin
			gcls = tcra_pkg::CLS_ARR;
		end
		do_grant = do_cmd && cmd.is_grant && any_ne;

		share_inc = {1'b0, share_q} + 1'b1;

		case (sel_cls_q)
			tcra_pkg::CLS_EMG: sel_rd = emg_rd;
			tcra_pkg::CLS_DEP: sel_rd = dep_rd;
			default:           sel_rd = arr_rd;
		endcase

		out_load = (do_cmd && !do_grant) || (state_q == ST_READ);

		res_d = '0;
		if (state_q == ST_READ) begin
			id_ext              = 32'(sel_rd.id);
			res_d.accepted      = 1'b1;
			res_d.flight_id     = id_ext[tcra_pkg::PID_W-1:0];
			res_d.served_class  = sel_cls_q;
			res_d.request_stamp = sel_rd.stamp;
			res_d.wait_time     = now_q - sel_rd.stamp;
		end else begin
			id_ext = 32'(new_id);
			if (!cmd.is_grant) begin
				res_d.accepted      = !full;
				res_d.flight_id     = full ? '0 : id_ext[tcra_pkg::PID_W-1:0];
				res_d.served_class  = cmd.cls;
				res_d.request_stamp = cmd.stamp;
			end
		end
	end

	tcra_fifo u_emg (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_ok && cmd.cls == tcra_pkg::CLS_EMG),
		.push_entry (new_entry),
		.pop        (do_grant && gcls == tcra_pkg::CLS_EMG),
		.rd_data_q  (emg_rd),
		.count      (emg_cnt)
	);

	tcra_fifo u_arr (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_ok && cmd.cls == tcra_pkg::CLS_ARR),
		.push_entry (new_entry),
		.pop        (do_grant && gcls == tcra_pkg::CLS_ARR),
		.rd_data_q  (arr_rd),
		.count      (arr_cnt)
	);

	tcra_fifo u_dep (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_ok && cmd.cls == tcra_pkg::CLS_DEP),
		.push_entry (new_entry),
		.pop        (do_grant && gcls == tcra_pkg::CLS_DEP),
		.rd_data_q  (dep_rd),
		.count      (dep_cnt)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= res_d;
		end
		if (do_grant) begin
			sel_cls_q <= gcls;
			now_q     <= cmd.stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			id_ctr_q    <= '0;
			share_q     <= '0;
			limit_q     <= tcra_pkg::LIMIT_W'(5);
			window_q    <= tcra_pkg::SHARE_W'(10);
			dshare_q    <= tcra_pkg::SHARE_W'(4);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcra_pkg::CFG_BACKLOG_LIMIT: limit_q  <= cfg_wdata;
					tcra_pkg::CFG_SHARE_WINDOW:  window_q <= cfg_wdata[tcra_pkg::SHARE_W-1:0];
					tcra_pkg::CFG_DEPART_SHARE:  dshare_q <= cfg_wdata[tcra_pkg::SHARE_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (req_ok) begin
				id_ctr_q <= id_ctr_q + 1'b1;
			end

			if (do_grant) begin
				state_q <= ST_READ;
				if (gcls != tcra_pkg::CLS_EMG) begin
					if (share_inc >= {1'b0, window_q}) begin
						share_q <= '0;
					end else begin
						share_q <= share_inc[tcra_pkg::SHARE_W-1:0];
					end
				end
			end else if (state_q == ST_READ) begin
				state_q <= ST_IDLE;
			end
		end
	end

endmodule

// ===== verif/three_class_runway_arbiter_test.sv =====
// Self-checking testbench for the three-class runway arbiter: a directed opening, then random
// request and grant traffic under several rule settings and handshake idling patterns.
// Depends on tcra_pkg and three_class_runway_arbiter; nothing else is read or loaded.
`timescale 1ns / 100ps

module three_class_runway_arbiter_test;

	// This bound only catches a hang; a correct run stays well below it.
	localparam int CYCLE_LIMIT = 100_000;

	// One input word as the sender sees it.
	typedef struct {
		tcra_pkg::op_t op;
		logic [31:0]   stamp_now;
	} req_word_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tcra_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tcra_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// Fields from bit 0 up: op [1:0], time_now [33:2], zero fill [39:34].
	logic [tcra_pkg::IN_W-1:0]       s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// Fields from bit 0 up: accepted [0], flight_id [16:1], served_class [18:17],
	// request_stamp [50:19], wait_time [82:51], zero fill [87:83].
	logic [tcra_pkg::OUT_W-1:0]      m_tdata;

	three_class_runway_arbiter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	// Words waiting to be sent, the word currently on the bus, and the results still owed.
	req_word_t         pending_words[$];
	req_word_t         drive_word;
	logic              word_live = 1'b0;
	tcra_pkg::result_t slot_outcomes[$];

	// Our own copy of the arbiter state: three waiting lines, the ID and share counters,
	// and the rule registers as last written.
	tcra_pkg::entry_t emg_line[$];
	tcra_pkg::entry_t arr_line[$];
	tcra_pkg::entry_t dep_line[$];
	logic [14:0]      id_ctr = '0;
	logic [3:0]       share_ctr = '0;
	logic [4:0]       backlog_limit_q = 5'd5;
	logic [3:0]       share_window_q = 4'd10;
	logic [3:0]       depart_share_q = 4'd4;

	// Idling percentages of the current phase and a running timestamp for the traffic.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [31:0] clock_stamp = 32'd1000;

	int                cycle_count = 0;
	int                mismatches = 0;
	int                results_checked = 0;
	int                words_sent = 0;
	int                grants_given = 0;
	int                requests_refused = 0;
	int                id_wraps = 0;
	tcra_pkg::result_t got_word;
	tcra_pkg::result_t want_word;

	task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("mismatch at result %0d: %s, got %0h, expected %0h",
			results_checked, what, got, want);
	endtask

	// Works out the single result a word causes and advances the state copy.
	task automatic arbitrate_word(input req_word_t w);
		tcra_pkg::result_t r;
		tcra_pkg::entry_t  e;
		logic              arr_empty;
		logic              room;
		r = '0;
		if (w.op != tcra_pkg::OP_GRANT) begin
			e.id = {id_ctr, w.op == tcra_pkg::OP_DEP};
			e.stamp = w.stamp_now;
			r.request_stamp = w.stamp_now;
			room = 1'b0;
			case (w.op)
				tcra_pkg::OP_ARR: begin
					r.served_class = tcra_pkg::CLS_ARR;
					if (arr_line.size() < tcra_pkg::QUEUE_DEPTH) begin
						arr_line.insert(arr_line.size(), e);
						room = 1'b1;
					end
				end
				tcra_pkg::OP_EMG: begin
					r.served_class = tcra_pkg::CLS_EMG;
					if (emg_line.size() < tcra_pkg::QUEUE_DEPTH) begin
						emg_line.insert(emg_line.size(), e);
						room = 1'b1;
					end
				end
				default: begin
					r.served_class = tcra_pkg::CLS_DEP;
					if (dep_line.size() < tcra_pkg::QUEUE_DEPTH) begin
						dep_line.insert(dep_line.size(), e);
						room = 1'b1;
					end
				end
			endcase
			// A refused request keeps its ID field at zero and does not use up an ID.
			if (room) begin
				r.accepted = 1'b1;
				r.flight_id = e.id;
				id_ctr = id_ctr + 15'd1;
				if (id_ctr == '0)
					id_wraps++;
			end else begin
				requests_refused++;
			end
		end else if (emg_line.size() != 0) begin
			// Emergencies jump every other class and leave the share counter alone.
			e = emg_line[0];
			emg_line.delete(0);
			r.accepted = 1'b1;
			r.served_class = tcra_pkg::CLS_EMG;
			r.flight_id = e.id;
			r.request_stamp = e.stamp;
			r.wait_time = w.stamp_now - e.stamp;
			grants_given++;
		end else if (arr_line.size() != 0 || dep_line.size() != 0) begin
			// A departure goes ahead of waiting arrivals only inside its share of the window
			// and only while its backlog is over the limit; with no arrival both rules lapse.
			arr_empty = (arr_line.size() == 0);
			if (dep_line.size() != 0 && (share_ctr < depart_share_q || arr_empty)
					&& (dep_line.size() > backlog_limit_q || arr_empty)) begin
				e = dep_line[0];
				dep_line.delete(0);
				r.served_class = tcra_pkg::CLS_DEP;
			end else begin
				e = arr_line[0];
				arr_line.delete(0);
				r.served_class = tcra_pkg::CLS_ARR;
			end
			r.accepted = 1'b1;
			r.flight_id = e.id;
			r.request_stamp = e.stamp;
			r.wait_time = w.stamp_now - e.stamp;
			if (share_ctr + 5'd1 >= share_window_q)
				share_ctr = '0;
			else
				share_ctr = share_ctr + 4'd1;
			grants_given++;
		end
		// A grant that finds every line empty leaves the all-zero result.
		slot_outcomes.insert(slot_outcomes.size(), r);
	endtask

	// Sender: a word stays on the bus until it is taken; between words the sender may idle.
	always @(negedge clk) begin
		if (!word_live) begin
			if (arst_n && pending_words.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				drive_word = pending_words[0];
				pending_words.delete(0);
				word_live = 1'b1;
				s_tvalid <= 1'b1;
				s_tdata <= {6'b0, drive_word.stamp_now, drive_word.op};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stalls at random according to the phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// At every rising edge: predict the word taken, then check the result word taken.
	// Prediction comes first so a result could never overtake its own expectation.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, slot_outcomes.size());
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				arbitrate_word(drive_word);
				word_live = 1'b0;
				words_sent++;
			end
			if (m_tvalid && m_tready) begin
				got_word.accepted = m_tdata[0];
				got_word.flight_id = m_tdata[16:1];
				got_word.served_class = tcra_pkg::cls_t'(m_tdata[18:17]);
				got_word.request_stamp = m_tdata[50:19];
				got_word.wait_time = m_tdata[82:51];
				results_checked++;
				if (slot_outcomes.size() == 0) begin
					flag_mismatch("result word with nothing expected", m_tdata[31:0], '0);
				end else begin
					want_word = slot_outcomes[0];
					slot_outcomes.delete(0);
					if (got_word.accepted !== want_word.accepted)
						flag_mismatch("accepted", got_word.accepted, want_word.accepted);
					if (got_word.flight_id !== want_word.flight_id)
						flag_mismatch("flight_id", got_word.flight_id, want_word.flight_id);
					if (got_word.served_class !== want_word.served_class)
						flag_mismatch("served_class", got_word.served_class,
							want_word.served_class);
					if (got_word.request_stamp !== want_word.request_stamp)
						flag_mismatch("request_stamp", got_word.request_stamp,
							want_word.request_stamp);
					if (got_word.wait_time !== want_word.wait_time)
						flag_mismatch("wait_time", got_word.wait_time, want_word.wait_time);
				end
			end
		end
	end

	task automatic queue_word(input tcra_pkg::op_t op, input logic [31:0] stamp_now);
		req_word_t w;
		w.op = op;
		w.stamp_now = stamp_now;
		pending_words.insert(pending_words.size(), w);
	endtask

	// Mostly a slowly rising clock; now and then any 32-bit value, so wait times wrap too.
	function automatic logic [31:0] next_stamp();
		if ($urandom_range(99) < 12)
			return $urandom;
		clock_stamp = clock_stamp + $urandom_range(0, 40);
		return clock_stamp;
	endfunction

	function automatic tcra_pkg::op_t pick_request(input int dep_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < dep_pct)
			return tcra_pkg::OP_DEP;
		if (roll < dep_pct + (100 - dep_pct) * 3 / 4)
			return tcra_pkg::OP_ARR;
		return tcra_pkg::OP_EMG;
	endfunction

	// Random traffic in bursts: filling bursts push lines toward full and refusal,
	// draining bursts walk the grant rules through every share counter value.
	task automatic queue_traffic(input int count);
		int made;
		int burst_len;
		int grant_pct;
		int dep_pct;
		made = 0;
		while (made < count) begin
			burst_len = $urandom_range(4, 30);
			case ($urandom_range(3))
				0: begin grant_pct = 15; dep_pct = 45; end
				1: begin grant_pct = 80; dep_pct = 45; end
				2: begin grant_pct = 40; dep_pct = 80; end
				default: begin grant_pct = 50; dep_pct = 40; end
			endcase
			repeat (burst_len) begin
				if ($urandom_range(99) < grant_pct)
					queue_word(tcra_pkg::OP_GRANT, next_stamp());
				else
					queue_word(pick_request(dep_pct), next_stamp());
				made++;
			end
		end
	endtask

	// Returns once every word has been sent and every result has come back, and then
	// idles on so that nothing is left inside the block.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() != 0 || word_live || slot_outcomes.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Writes all three rule registers while the block is idle and mirrors them.
	task automatic load_runway_rules(input logic [4:0] limit, input logic [3:0] window,
			input logic [3:0] share);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tcra_pkg::CFG_BACKLOG_LIMIT;
		cfg_wdata <= limit;
		@(negedge clk);
		cfg_index <= tcra_pkg::CFG_SHARE_WINDOW;
		cfg_wdata <= {1'b0, window};
		@(negedge clk);
		cfg_index <= tcra_pkg::CFG_DEPART_SHARE;
		cfg_wdata <= {1'b0, share};
		@(negedge clk);
		cfg_we <= 1'b0;
		backlog_limit_q = limit;
		share_window_q = window;
		depart_share_q = share;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
			default: begin send_idle_pct = 25; recv_stall_pct = 25; end
		endcase
	endtask

	initial begin : stimulus
		int phase;
		logic [4:0] limit;
		logic [3:0] window;
		logic [3:0] share;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening under the reset rules: a grant into empty lines, extreme
		// stamps, an emergency line filled to refusal, and emergency waits that wrap.
		queue_word(tcra_pkg::OP_GRANT, 32'd100);
		queue_word(tcra_pkg::OP_ARR, 32'h0000_0000);
		queue_word(tcra_pkg::OP_DEP, 32'hFFFF_FFFF);
		for (int i = 0; i < tcra_pkg::QUEUE_DEPTH + 1; i++)
			queue_word(tcra_pkg::OP_EMG, 32'hFFFF_FFF0 + i);
		queue_word(tcra_pkg::OP_GRANT, 32'd5);
		queue_word(tcra_pkg::OP_GRANT, 32'd6);
		queue_word(tcra_pkg::OP_ARR, 32'h5555_5555);
		queue_word(tcra_pkg::OP_DEP, 32'hAAAA_AAAA);
		wait_drained();

		// Random phases, each under new rules and one of four idling patterns; the first four
		// settings take window and share to their extremes and the limit to 0 and the queue depth.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin limit = 5'd0;  window = 4'd1;  share = 4'd0;  end
				1: begin limit = 5'd16; window = 4'd15; share = 4'd15; end
				2: begin limit = 5'd2;  window = 4'd15; share = 4'd0;  end
				3: begin limit = 5'd0;  window = 4'd15; share = 4'd15; end
				default: begin
					limit = $urandom_range(0, 16);
					window = $urandom_range(1, 15);
					share = $urandom_range(0, 15);
				end
			endcase
			load_runway_rules(limit, window, share);
			set_idling(phase);
			queue_traffic(300);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("checked %0d result words for %0d input words under 7 rule settings",
			results_checked, words_sent);
		$display("planes granted %0d, requests refused %0d, ID counter wraps %0d",
			grants_given, requests_refused, id_wraps);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
